### hw/rtl/lps_pkg.sv
// Package for the latency percentile summary block.
// Shared constants and the front-to-back request struct; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lps_pkg;
  localparam int MaxSamplesDefault = 1024;
  localparam int PctNum = 99;
  localparam int PctDen = 100;
  localparam int SampleW = 32;
  localparam int CountW = 11;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last;
  } lps_req_t;
endpackage
`default_nettype wire

### hw/rtl/lps_front.sv
// Front end: accepts samples into a short queue towards the back end.
// Depends on lps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lps_front
  import lps_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [SampleW-1:0] latency_ns,
  input  wire logic             last_sample,
  output logic                  req_valid,
  output lps_req_t              req,
  input  wire logic             req_take
);
  lps_req_t q [2];
  logic     rd_ptr;
  logic     wr_ptr;
  logic [1:0] fill;
  logic     do_push;
  logic     do_pop;

  assign full      = (fill == 2'd2);
  assign req_valid = (fill != 2'd0);
  assign req       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= '{sample: latency_ns, last: last_sample};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule
`default_nettype wire

### hw/rtl/lps_back.sv
// Back end: sorted insertion into memory, running sum, divider and summary.
// Depends on lps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lps_back
  import lps_pkg::*;
#(
  parameter int MAX_SAMPLES = MaxSamplesDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire lps_req_t         req,
  output logic                  req_take,
  output logic                  empty,
  input  wire logic             pop,
  output logic [SampleW-1:0]    mean_ns,
  output logic [SampleW-1:0]    best_ns,
  output logic [SampleW-1:0]    median_ns,
  output logic [SampleW-1:0]    p99_ns,
  output logic [SampleW-1:0]    worst_ns,
  output logic [CountW-1:0]     sample_count,
  output logic                  overflow
);
  localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int NW   = $clog2(MAX_SAMPLES + 1);
  localparam int SumW = SampleW + NW;
  localparam int MulW = NW + 7;
  // ceil(PctNum * 2^32 / PctDen): the top bits of count times this give the
  // exact truncated 99th percentile index for any count below 2^25.
  localparam logic [31:0] P99Recip =
    32'(((64'(PctNum) << 32) + 64'(PctDen) - 64'd1) / 64'(PctDen));

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT_RD, S_SHIFT_CMP, S_PLACE, S_IDX, S_RD_BEST, S_RD_MED,
    S_RD_P99, S_RD_WORST, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic [SampleW-1:0] mem [MAX_SAMPLES];
  logic [SampleW-1:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [SampleW-1:0] wr_data;

  logic [NW-1:0]      kept;
  logic [SumW-1:0]    sum;
  logic               dropped;
  logic [SampleW-1:0] cur;
  logic               cur_last;
  logic [NW-1:0]      pos;
  logic [MulW-1:0]    p99_idx;
  logic [NW+31:0]     p99_prod;
  logic [NW-1:0]      med_idx;
  logic [SumW-1:0]    rem;
  logic [SumW-1:0]    quo;
  logic [$clog2(SumW+1)-1:0] div_cnt;
  logic [SumW:0]      rem_sh;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Memory control decoded from state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = pos[AW-1:0];
    wr_data = cur;
    case (state)
      S_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(pos - 1'b1);
      end
      S_SHIFT_CMP: begin
        wr_en = (rd_data > cur);
        wr_data = rd_data;
      end
      S_PLACE:    wr_en = 1'b1;
      S_IDX: begin
        rd_en = 1'b1; rd_addr = '0;
      end
      S_RD_BEST: begin
        rd_en = 1'b1; rd_addr = AW'(med_idx);
      end
      S_RD_MED: begin
        rd_en = 1'b1; rd_addr = AW'(p99_idx);
      end
      S_RD_P99: begin
        rd_en = 1'b1; rd_addr = AW'(kept - 1'b1);
      end
      default: ;
    endcase
  end

  assign p99_prod = (NW+32)'(kept) * (NW+32)'(P99Recip);
  assign rem_sh   = {rem, quo[SumW-1]};
  assign req_take = (state == S_IDLE) && req_valid;
  assign empty    = (state != S_OUT);
  assign mean_ns  = quo[SampleW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      kept    <= '0;
      sum     <= '0;
      dropped <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (req_valid) begin
          cur      <= req.sample;
          cur_last <= req.last;
          pos      <= kept;
          if (kept < NW'(MAX_SAMPLES)) begin
            sum  <= sum + SumW'(req.sample);
            kept <= kept + 1'b1;
            state <= (kept == '0) ? S_PLACE : S_SHIFT_RD;
          end else begin
            dropped <= 1'b1;
            state   <= req.last ? S_IDX : S_IDLE;
          end
        end
        S_SHIFT_RD: state <= S_SHIFT_CMP;
        S_SHIFT_CMP: begin
          if (rd_data > cur) begin
            pos   <= pos - 1'b1;
            state <= (pos == NW'(1)) ? S_PLACE : S_SHIFT_RD;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: state <= cur_last ? S_IDX : S_IDLE;
        S_IDX: begin
          med_idx <= kept >> 1;
          p99_idx <= MulW'(p99_prod >> 32);
          state   <= S_RD_BEST;
        end
        S_RD_BEST:  begin best_ns   <= rd_data; state <= S_RD_MED;   end
        S_RD_MED:   begin median_ns <= rd_data; state <= S_RD_P99;   end
        S_RD_P99:   begin p99_ns    <= rd_data; state <= S_RD_WORST; end
        S_RD_WORST: begin
          worst_ns <= rd_data;
          rem      <= '0;
          quo      <= sum;
          div_cnt  <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit a cycle.
          if (rem_sh >= (SumW+1)'(kept)) begin
            rem <= SumW'(rem_sh - (SumW+1)'(kept));
            quo <= {quo[SumW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[SumW-1:0];
            quo <= {quo[SumW-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == ($clog2(SumW+1))'(SumW-1)) begin
            sample_count <= CountW'(kept);
            overflow     <= dropped;
            state        <= S_OUT;
          end
        end
        S_OUT: if (pop) begin
          kept    <= '0;
          sum     <= '0;
          dropped <= 1'b0;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/latency_percentile_summary.sv
// Top level of the latency percentile summary block.
// Depends on lps_pkg, lps_front and lps_back.
`timescale 1ns / 1ps
`default_nettype none
// Samples are pushed through a two-entry queue into a back end that keeps
// them in ascending order in a single-port-style memory. Each kept sample is
// inserted by moving larger entries up one place; each entry moved is read
// in S_SHIFT_RD, then compared and written one place up in S_SHIFT_CMP.
// After the larger entries have moved, one more entry is read and compared
// before the sample is placed, unless the sample lands at the bottom of the
// store or the store is empty. A sample that arrives when the store is full
// is dropped and sets the overflow flag. On the sample marked last the block
// reads the minimum, median, 99th percentile and maximum from memory, then
// divides the running sum by the count with a bit-serial divider, and offers
// one result item until it is popped; the run is then cleared. The queue
// keeps accepting items while the back end works, until both its entries
// are full.
module latency_percentile_summary
  import lps_pkg::*;
#(
  parameter int MAX_SAMPLES = MaxSamplesDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [SampleW-1:0] latency_ns,
  input  wire logic               last_sample,
  output logic                    empty,
  input  wire logic               pop,
  output logic [SampleW-1:0]      mean_ns,
  output logic [SampleW-1:0]      best_ns,
  output logic [SampleW-1:0]      median_ns,
  output logic [SampleW-1:0]      p99_ns,
  output logic [SampleW-1:0]      worst_ns,
  output logic [CountW-1:0]       sample_count,
  output logic                    overflow
);
  logic     req_valid;
  logic     req_take;
  lps_req_t req;

  lps_front u_front (
    .clk, .rst, .push, .full, .latency_ns, .last_sample,
    .req_valid, .req, .req_take
  );

  lps_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk, .rst, .req_valid, .req, .req_take, .empty, .pop,
    .mean_ns, .best_ns, .median_ns, .p99_ns, .worst_ns,
    .sample_count, .overflow
  );

  // A result never reports a count of zero.
  assert property (@(posedge clk) disable iff (rst) !empty |-> sample_count != '0)
    else $error("result with zero sample count");

  // The extreme values bracket the percentiles.
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (best_ns <= median_ns) && (median_ns <= p99_ns) && (p99_ns <= worst_ns))
    else $error("result values out of order");

  // The mean lies between the minimum and maximum.
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (mean_ns >= best_ns) && (mean_ns <= worst_ns))
    else $error("mean outside sample range");
endmodule
`default_nettype wire
